// ----- rtl/core/lrfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Link receive frame decoder package
// Shared types, codes and address helpers for the link frame decoder.
// ----------------------------------------------------------------------------
package lrfd_pkg;

    localparam int ADDRESS_BITS = 32;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS = 32;

    typedef logic [ADDRESS_BITS-1:0] t_addr;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DMA_BASE        = 1'b0,
        CFG_INTERRUPT_COUNT = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_OFF_LO  = 3'd1,
        PH_OFF_HI  = 3'd2,
        PH_STORE   = 3'd3,
        PH_REPLY   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        EV_INTERRUPT = 3'd0,
        EV_ILLEGAL   = 3'd1,
        EV_STORE     = 3'd2,
        EV_FETCH     = 3'd3,
        EV_REPLY     = 3'd4
    } t_event_kind;

    typedef enum logic [1:0] {
        HDR_INTERRUPT = 2'b00,
        HDR_STORE     = 2'b01,
        HDR_FETCH     = 2'b10,
        HDR_IGNORED   = 2'b11
    } t_header_sel;

    function automatic t_addr addr_sum(input logic [31:0] base, input logic [15:0] offset);
        logic [63:0] sum;
        sum = 64'(base) + 64'(offset);
        return sum[ADDRESS_BITS-1:0];
    endfunction

    function automatic logic [31:0] addr_field(input t_addr addr);
        logic [63:0] wide;
        wide = 64'(addr);
        return wide[31:0];
    endfunction

endpackage

// ----- rtl/core/link_receive_frame_decoder.sv -----
// A result is registered on the output in the cycle after its byte transfer.
// Throughput: one byte per cycle; the input stalls only while a result waits downstream.
// Reset (synchronous, active low) returns the decoder to header search, clears
// the output valid and sets both configuration registers to zero.
// ----------------------------------------------------------------------------
// Link receive frame decoder
// Decodes interrupt, store, fetch and reply frames from a received byte stream.
// ----------------------------------------------------------------------------
module link_receive_frame_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lrfd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [lrfd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_rx_byte,
    output logic                                o_valid,
    input  logic                                i_stall,
    output lrfd_pkg::t_event_kind               o_event_kind,
    output logic [3:0]                          o_interrupt_number,
    output logic [31:0]                         o_target_address,
    output logic [7:0]                          o_data_byte,
    output logic [4:0]                          o_fetch_length,
    output logic                                o_run_end
);
    import lrfd_pkg::*;

    logic [31:0] r_dma_base;
    logic [4:0]  r_interrupt_count;

    t_phase      r_phase, n_phase;
    logic        r_frame_fetch, n_frame_fetch;
    logic [6:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_offset_low, n_offset_low;
    t_addr       r_addr, n_addr;

    logic        in_xfer;
    logic        ev_valid;
    t_event_kind ev_kind;
    logic [3:0]  ev_irq;
    logic [31:0] ev_addr;
    logic [7:0]  ev_data;
    logic [4:0]  ev_len;
    logic        ev_last;
    logic [6:0]  bytes_dec;
    t_addr       offset_addr;

    logic        r_valid;
    t_event_kind r_event_kind;
    logic [3:0]  r_interrupt_number;
    logic [31:0] r_target_address;
    logic [7:0]  r_data_byte;
    logic [4:0]  r_fetch_length;
    logic        r_run_end;

    assign o_stall = r_valid && i_stall;
    assign in_xfer = i_valid && !o_stall;
    assign bytes_dec = r_bytes_left - 7'd1;
    assign offset_addr = addr_sum(r_dma_base, {i_rx_byte, r_offset_low});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dma_base        <= '0;
            r_interrupt_count <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DMA_BASE:        r_dma_base        <= i_cfg_data;
                CFG_INTERRUPT_COUNT: r_interrupt_count <= i_cfg_data[4:0];
                default:             r_dma_base        <= r_dma_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_frame_fetch <= 1'b0;
            r_bytes_left  <= '0;
            r_offset_low  <= '0;
            r_addr        <= '0;
        end else begin
            r_phase       <= n_phase;
            r_frame_fetch <= n_frame_fetch;
            r_bytes_left  <= n_bytes_left;
            r_offset_low  <= n_offset_low;
            r_addr        <= n_addr;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_frame_fetch = r_frame_fetch;
        n_bytes_left  = r_bytes_left;
        n_offset_low  = r_offset_low;
        n_addr        = r_addr;
        ev_valid      = 1'b0;
        ev_kind       = EV_INTERRUPT;
        ev_irq        = '0;
        ev_addr       = '0;
        ev_data       = '0;
        ev_len        = '0;
        ev_last       = 1'b0;
        if (in_xfer) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (!i_rx_byte[7]) begin
                        n_bytes_left = i_rx_byte[6:0];
                        if (i_rx_byte[6:0] != 7'd0) begin
                            n_phase = PH_REPLY;
                        end
                    end else begin
                        case (t_header_sel'(i_rx_byte[6:5]))
                            HDR_INTERRUPT: begin
                                ev_valid = 1'b1;
                                ev_irq   = i_rx_byte[3:0];
                                ev_kind  = ({1'b0, i_rx_byte[3:0]} >= r_interrupt_count)
                                           ? EV_ILLEGAL : EV_INTERRUPT;
                            end
                            HDR_STORE, HDR_FETCH: begin
                                n_frame_fetch = i_rx_byte[6];
                                n_bytes_left  = {2'b00, i_rx_byte[4:0]};
                                n_phase       = PH_OFF_LO;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
                PH_OFF_LO: begin
                    n_offset_low = i_rx_byte;
                    n_phase      = PH_OFF_HI;
                end
                PH_OFF_HI: begin
                    n_addr = offset_addr;
                    if (r_frame_fetch) begin
                        ev_valid     = 1'b1;
                        ev_kind      = EV_FETCH;
                        ev_addr      = addr_field(offset_addr);
                        ev_len       = r_bytes_left[4:0];
                        n_bytes_left = '0;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_phase = (r_bytes_left != 7'd0) ? PH_STORE : PH_IDLE;
                    end
                end
                PH_STORE: begin
                    n_bytes_left = bytes_dec;
                    ev_valid     = 1'b1;
                    ev_kind      = EV_STORE;
                    ev_addr      = addr_field(r_addr);
                    ev_data      = i_rx_byte;
                    ev_last      = (bytes_dec == 7'd0);
                    n_addr       = r_addr + t_addr'(1);
                    if (bytes_dec == 7'd0) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_REPLY: begin
                    n_bytes_left = bytes_dec;
                    ev_valid     = 1'b1;
                    ev_kind      = EV_REPLY;
                    ev_data      = i_rx_byte;
                    ev_last      = (bytes_dec == 7'd0);
                    if (bytes_dec == 7'd0) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= in_xfer && ev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && ev_valid) begin
            r_event_kind       <= ev_kind;
            r_interrupt_number <= ev_irq;
            r_target_address   <= ev_addr;
            r_data_byte        <= ev_data;
            r_fetch_length     <= ev_len;
            r_run_end          <= ev_last;
        end
    end

    assign o_valid            = r_valid;
    assign o_event_kind       = r_event_kind;
    assign o_interrupt_number = r_interrupt_number;
    assign o_target_address   = r_target_address;
    assign o_data_byte        = r_data_byte;
    assign o_fetch_length     = r_fetch_length;
    assign o_run_end          = r_run_end;

endmodule

// ----- rtl/core/lrfd_checker.sv -----
// ----------------------------------------------------------------------------
// Link receive frame decoder checker
// Port-level assertions on the frame decoder, attached by bind.
// ----------------------------------------------------------------------------
module lrfd_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_stall,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  lrfd_pkg::t_event_kind               o_event_kind,
    input  logic [3:0]                          o_interrupt_number,
    input  logic [31:0]                         o_target_address,
    input  logic [7:0]                          o_data_byte,
    input  logic [4:0]                          o_fetch_length,
    input  logic                                o_run_end
);
    import lrfd_pkg::*;

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid set after reset.");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event_kind)
            && $stable(o_target_address) && $stable(o_data_byte))
        else $error("Stalled result transfer changed.");

    a_input_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("Input stalled while the output register could drain.");

    a_interrupt_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == EV_INTERRUPT || o_event_kind == EV_ILLEGAL)
            |-> o_target_address == 32'd0 && o_data_byte == 8'd0 && !o_run_end
                && o_fetch_length == 5'd0)
        else $error("Interrupt result carries transfer fields.");

    a_fetch_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind == EV_FETCH
            |-> o_data_byte == 8'd0 && !o_run_end && o_interrupt_number == 4'd0)
        else $error("Fetch request carries data fields.");

endmodule

bind link_receive_frame_decoder lrfd_checker u_lrfd_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Link receive frame decoder testbench
// Sends directed and random link byte streams through the decoder, predicts
// every event in a behavioral model of the frame parser, and compares each
// event transfer field by field while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    import lrfd_pkg::*;

    localparam int RUN_LIMIT = 600_000;
    localparam int PHASE_ITEMS = 215;
    localparam int PHASE_COUNT = 8;

    typedef struct {
        t_event_kind kind;
        logic [3:0]  irq;
        logic [31:0] addr;
        logic [7:0]  data;
        logic [4:0]  len;
        logic        last;
    } t_decode_result;

    typedef enum {ROW_BYTE, ROW_TYPED, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind      kind;
        logic [7:0]     rx;
        t_cfg_index     cfg_sel;
        logic [31:0]    value;
        t_decode_result want;
    } t_row;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} t_stall_mode;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;
    logic                      i_valid;
    logic                      o_stall;
    logic [7:0]                i_rx_byte;
    logic                      o_valid;
    logic                      i_stall;
    t_event_kind               o_event_kind;
    logic [3:0]                o_interrupt_number;
    logic [31:0]               o_target_address;
    logic [7:0]                o_data_byte;
    logic [4:0]                o_fetch_length;
    logic                      o_run_end;

    link_receive_frame_decoder DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_rx_byte          (i_rx_byte),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_event_kind       (o_event_kind),
        .o_interrupt_number (o_interrupt_number),
        .o_target_address   (o_target_address),
        .o_data_byte        (o_data_byte),
        .o_fetch_length     (o_fetch_length),
        .o_run_end          (o_run_end)
    );

    always #6 i_clk = ~i_clk;

    // Parser state and register copies mirrored from the decoder.
    t_phase         parse_phase = PH_IDLE;
    logic           fetch_frame = 1'b0;
    logic [6:0]     bytes_left = '0;
    logic [7:0]     offset_low = '0;
    t_addr          run_addr = '0;
    logic [31:0]    base_reg = '0;
    logic [4:0]     irq_limit = '0;

    t_decode_result expected_events[$];
    t_row           directed_rows[$];
    t_decode_result blank_result;
    int             mismatches = 0;
    int             items_sent = 0;
    int             burst_left = 0;
    int             cycles = 0;

    function automatic bit decode_byte(input logic [7:0] b, output t_decode_result r);
        logic [63:0] wide;
        r.kind = EV_INTERRUPT;
        r.irq = '0;
        r.addr = '0;
        r.data = '0;
        r.len = '0;
        r.last = 1'b0;
        decode_byte = 1'b0;
        case (parse_phase)
            PH_IDLE: begin
                if (!b[7]) begin
                    bytes_left = b[6:0];
                    if (bytes_left != 0)
                        parse_phase = PH_REPLY;
                end else begin
                    case (t_header_sel'(b[6:5]))
                        HDR_INTERRUPT: begin
                            r.kind = ({1'b0, b[3:0]} >= irq_limit) ? EV_ILLEGAL : EV_INTERRUPT;
                            r.irq = b[3:0];
                            decode_byte = 1'b1;
                        end
                        HDR_STORE, HDR_FETCH: begin
                            fetch_frame = (t_header_sel'(b[6:5]) == HDR_FETCH);
                            bytes_left = {2'b00, b[4:0]};
                            parse_phase = PH_OFF_LO;
                        end
                        default: ;
                    endcase
                end
            end
            PH_OFF_LO: begin
                offset_low = b;
                parse_phase = PH_OFF_HI;
            end
            PH_OFF_HI: begin
                wide = 64'(base_reg) + 64'({b, offset_low});
                run_addr = wide[ADDRESS_BITS-1:0];
                if (fetch_frame) begin
                    wide = 64'(run_addr);
                    r.kind = EV_FETCH;
                    r.addr = wide[31:0];
                    r.len = bytes_left[4:0];
                    bytes_left = '0;
                    parse_phase = PH_IDLE;
                    decode_byte = 1'b1;
                end else begin
                    parse_phase = (bytes_left != 0) ? PH_STORE : PH_IDLE;
                end
            end
            PH_STORE, PH_REPLY: begin
                bytes_left = bytes_left - 7'd1;
                r.last = (bytes_left == 0);
                r.data = b;
                if (parse_phase == PH_STORE) begin
                    wide = 64'(run_addr);
                    r.kind = EV_STORE;
                    r.addr = wide[31:0];
                    run_addr = run_addr + t_addr'(1);
                end else begin
                    r.kind = EV_REPLY;
                end
                if (r.last)
                    parse_phase = PH_IDLE;
                decode_byte = 1'b1;
            end
            default: parse_phase = PH_IDLE;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_byte(input logic [7:0] b, input bit use_typed,
                             input t_decode_result typed);
        t_decode_result r;
        bit             got;
        if (burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 20);
        end
        burst_left--;
        i_valid = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (o_stall);
        if (!(parse_phase == PH_IDLE && b[7] && t_header_sel'(b[6:5]) == HDR_IGNORED))
            items_sent++;
        got = decode_byte(b, r);
        if (use_typed)
            expected_events.push_back(typed);
        else if (got)
            expected_events.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [31:0] value);
        i_valid = 1'b0;
        while (expected_events.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        if (idx == CFG_DMA_BASE)
            base_reg = value;
        else
            irq_limit = value[4:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        i_cfg_data = $urandom;
    endtask

    task automatic send_frame();
        int          pick;
        logic [4:0]  cnt;
        logic [6:0]  reply_cnt;
        logic [7:0]  lo;
        logic [7:0]  hi;
        pick = $urandom_range(0, 99);
        cnt = 5'($urandom_range(0, 6));
        lo = 8'($urandom);
        hi = 8'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            lo = 8'hff;
            hi = 8'hff;
        end
        if (pick < 12) begin
            send_byte({1'b1, HDR_INTERRUPT, 5'($urandom)}, 1'b0, blank_result);
        end else if (pick < 40) begin
            if ($urandom_range(0, 9) == 0)
                cnt = ($urandom_range(0, 1) == 0) ? 5'd31 : 5'($urandom);
            send_byte({1'b1, HDR_STORE, cnt}, 1'b0, blank_result);
            send_byte(lo, 1'b0, blank_result);
            send_byte(hi, 1'b0, blank_result);
            repeat (cnt) send_byte(8'($urandom), 1'b0, blank_result);
        end else if (pick < 60) begin
            send_byte({1'b1, HDR_FETCH, 5'($urandom)}, 1'b0, blank_result);
            send_byte(lo, 1'b0, blank_result);
            send_byte(hi, 1'b0, blank_result);
        end else if (pick < 85) begin
            reply_cnt = 7'($urandom_range(0, 8));
            if ($urandom_range(0, 19) == 0)
                reply_cnt = ($urandom_range(0, 1) == 0) ? 7'd127 : 7'($urandom);
            send_byte({1'b0, reply_cnt}, 1'b0, blank_result);
            repeat (reply_cnt) send_byte(8'($urandom), 1'b0, blank_result);
        end else if (pick < 90) begin
            send_byte({1'b1, HDR_IGNORED, 5'($urandom)}, 1'b0, blank_result);
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, blank_result);
        end
    endtask

    task automatic row_byte(input logic [7:0] b);
        t_row row;
        row.kind = ROW_BYTE;
        row.rx = b;
        directed_rows.push_back(row);
    endtask

    task automatic row_typed(input logic [7:0] b, input t_event_kind kind,
                             input logic [3:0] irq, input logic [31:0] addr,
                             input logic [7:0] data, input logic [4:0] len,
                             input logic last);
        t_row row;
        row.kind = ROW_TYPED;
        row.rx = b;
        row.want.kind = kind;
        row.want.irq = irq;
        row.want.addr = addr;
        row.want.data = data;
        row.want.len = len;
        row.want.last = last;
        directed_rows.push_back(row);
    endtask

    task automatic row_config(input t_cfg_index idx, input logic [31:0] value);
        t_row row;
        row.kind = ROW_CONFIG;
        row.cfg_sel = idx;
        row.value = value;
        directed_rows.push_back(row);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : event_monitor
        t_decode_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_events.size() == 0) begin
                $display("%0t ns: event kind 0x%0h expected none, actual transfer",
                         $time, o_event_kind);
                mismatches++;
            end else begin
                want = expected_events.pop_front();
                check_field("event_kind", 32'(want.kind), 32'(o_event_kind));
                check_field("interrupt_number", 32'(want.irq), 32'(o_interrupt_number));
                check_field("target_address", want.addr, o_target_address);
                check_field("data_byte", 32'(want.data), 32'(o_data_byte));
                check_field("fetch_length", 32'(want.len), 32'(o_fetch_length));
                check_field("run_end", 32'(want.last), 32'(o_run_end));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // The receiver alternates between free, random and periodic stalling, with
    // a long hold-off now and then that lets the decoder back up to its input.
    initial begin : receiver
        int          segment;
        int          span;
        int          period;
        t_stall_mode mode;
        segment = 0;
        i_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            segment++;
            if (segment % 10 == 4) begin
                i_stall = 1'b1;
                repeat (80) @(negedge i_clk);
            end else begin
                mode = t_stall_mode'($urandom_range(0, 2));
                span = $urandom_range(10, 60);
                period = $urandom_range(2, 5);
                for (int c = 0; c < span; c++) begin
                    case (mode)
                        STALL_NONE:     i_stall = 1'b0;
                        STALL_RANDOM:   i_stall = 1'($urandom_range(0, 1));
                        STALL_PERIODIC: i_stall = (c % period == 0);
                        default:        i_stall = 1'b0;
                    endcase
                    @(negedge i_clk);
                end
            end
            i_stall = 1'b0;
        end
    end

    initial begin : stimulus
        int phase_start;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_DMA_BASE;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_rx_byte = '0;

        // Reset values: base zero and no legal interrupt numbers.
        row_typed(8'h80, EV_ILLEGAL, 4'h0, '0, '0, '0, 1'b0);
        row_typed(8'h9f, EV_ILLEGAL, 4'hf, '0, '0, '0, 1'b0);
        row_byte(8'he0);
        row_byte(8'hff);
        row_byte(8'h00);
        row_byte(8'h01);
        row_typed(8'hff, EV_REPLY, 4'h0, '0, 8'hff, '0, 1'b1);
        row_byte(8'ha0);
        row_byte(8'h12);
        row_byte(8'h34);
        row_byte(8'hc0);
        row_byte(8'hff);
        row_typed(8'hff, EV_FETCH, 4'h0, 32'h0000_ffff, '0, 5'd0, 1'b0);
        row_byte(8'hdf);
        row_byte(8'h00);
        row_typed(8'h00, EV_FETCH, 4'h0, 32'h0, '0, 5'd31, 1'b0);
        row_config(CFG_DMA_BASE, 32'hffff_ffff);
        row_config(CFG_INTERRUPT_COUNT, 32'd16);
        row_typed(8'h80, EV_INTERRUPT, 4'h0, '0, '0, '0, 1'b0);
        row_typed(8'h8f, EV_INTERRUPT, 4'hf, '0, '0, '0, 1'b0);
        row_byte(8'ha2);
        row_byte(8'h01);
        row_byte(8'h00);
        // The base was taken with the high offset byte; this write must not
        // move the store run that is already under way.
        row_config(CFG_DMA_BASE, 32'h1000_0000);
        row_byte(8'h00);
        row_byte(8'hff);
        row_config(CFG_INTERRUPT_COUNT, 32'd31);
        row_typed(8'h8f, EV_INTERRUPT, 4'hf, '0, '0, '0, 1'b0);
        row_config(CFG_INTERRUPT_COUNT, 32'd5);
        row_typed(8'h85, EV_ILLEGAL, 4'h5, '0, '0, '0, 1'b0);
        row_typed(8'h84, EV_INTERRUPT, 4'h4, '0, '0, '0, 1'b0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_CONFIG)
                write_register(directed_rows[n].cfg_sel, directed_rows[n].value);
            else
                send_byte(directed_rows[n].rx, directed_rows[n].kind == ROW_TYPED,
                          directed_rows[n].want);
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin
                    write_register(CFG_DMA_BASE, 32'h0);
                    write_register(CFG_INTERRUPT_COUNT, 32'd0);
                end
                1: begin
                    write_register(CFG_DMA_BASE, 32'hffff_ffff);
                    write_register(CFG_INTERRUPT_COUNT, 32'd16);
                end
                2: begin
                    write_register(CFG_DMA_BASE, 32'hffff_ff00);
                    write_register(CFG_INTERRUPT_COUNT, 32'd31);
                end
                3: begin
                    write_register(CFG_DMA_BASE, 32'hffff_0000);
                    write_register(CFG_INTERRUPT_COUNT, 32'd1);
                end
                default: begin
                    write_register(CFG_DMA_BASE, $urandom);
                    write_register(CFG_INTERRUPT_COUNT, $urandom_range(0, 31));
                end
            endcase
            phase_start = items_sent;
            while (items_sent < phase_start + PHASE_ITEMS)
                send_frame();
        end

        i_valid = 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
